/* design/bcc_pkg.sv */
// Package for the barycentric coordinate unit.
// Holds the result format constants shared by the back end, top level and checker.
// No dependencies.
package bcc_pkg;

   // Width of one weight on the result channel.
   localparam int RESULT_WIDTH = 32;

   // Quotient bits produced by the divider: one more than the result width,
   // so that an out-of-range magnitude is still recognized before clamping.
   localparam int QUOT_BITS = RESULT_WIDTH + 1;

   // Saturation limits of a signed result.
   localparam logic [RESULT_WIDTH-1:0] RES_MAX = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
   localparam logic [RESULT_WIDTH-1:0] RES_MIN = {1'b1, {(RESULT_WIDTH-1){1'b0}}};

endpackage

/* design/bcc_front.sv */
// Front end of the barycentric coordinate unit: edge vectors, dot products,
// the wide products and the numerators and denominator of the weights.
// Depends on no package; widths follow from the coordinate width.
module bcc_front #(
   parameter int CW = 16,
   localparam int NW = 4*CW + 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic signed [CW-1:0] vert_a [3],
   input  logic signed [CW-1:0] vert_b [3],
   input  logic signed [CW-1:0] vert_c [3],
   input  logic signed [CW-1:0] point_p [3],
   output logic                 out_valid,
   input  logic                 out_full,
   output logic signed [NW-1:0] out_den,
   output logic signed [NW-1:0] out_nv,
   output logic signed [NW-1:0] out_nw,
   output logic signed [NW-1:0] out_nu,
   output logic                 out_degenerate
);

   localparam int EW  = CW + 1;
   localparam int DW  = 2*CW + 4;
   localparam int HW  = (DW + 1) / 2;
   localparam int PPW = 2*HW + 2;
   localparam int PW  = 2*DW;
   localparam int NS  = 7;

   // Dot product slots.
   localparam int D00 = 0;
   localparam int D01 = 1;
   localparam int D11 = 2;
   localparam int D20 = 3;
   localparam int D21 = 4;

   // Operand pairs of the six wide products:
   // d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20.
   localparam int PX [6] = '{D00, D01, D11, D01, D00, D01};
   localparam int PY [6] = '{D11, D01, D20, D21, D21, D20};

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_prev;
   logic [NS:0]   en;

   logic signed [EW-1:0]   e0_ff [3], e1_ff [3], e2_ff [3];
   logic signed [EW-1:0]   e0_in [3], e1_in [3], e2_in [3];
   logic signed [2*EW-1:0] pr_ff [5][3];
   logic signed [2*EW-1:0] pr_in [5][3];
   logic signed [DW-1:0]   dot_ff [5];
   logic signed [DW-1:0]   dot_in [5];
   logic signed [PPW-1:0]  hh_ff [6], hl_ff [6], lh_ff [6], ll_ff [6];
   logic signed [PPW-1:0]  hh_in [6], hl_in [6], lh_in [6], ll_in [6];
   logic signed [PW-1:0]   prod_ff [6];
   logic signed [PW-1:0]   prod_in [6];
   logic signed [NW-1:0]   den6_ff, nv6_ff, nw6_ff;
   logic signed [NW-1:0]   den6_in, nv6_in, nw6_in;
   logic signed [NW-1:0]   den_ff, nv_ff, nw_ff, nu_ff;
   logic signed [NW-1:0]   nu_in;
   logic                   deg_ff;
   logic                   deg_in;

   // Stall chain: a stage loads when it is empty or its content moves on.
   always_comb begin
      en[NS] = !out_full;
      for (int s = NS-1; s >= 0; s--) begin
         en[s] = !vld_ff[s] || en[s+1];
      end
   end

   assign vld_prev = {vld_ff[NS-2:0], in_valid};
   assign in_stall = !en[0];

   // Edge vectors relative to vertex a.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e0_in[k] = {vert_b[k][CW-1], vert_b[k]} - {vert_a[k][CW-1], vert_a[k]};
         e1_in[k] = {vert_c[k][CW-1], vert_c[k]} - {vert_a[k][CW-1], vert_a[k]};
         e2_in[k] = {point_p[k][CW-1], point_p[k]} - {vert_a[k][CW-1], vert_a[k]};
      end
   end

   // Per-axis products of the edge components.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pr_in[D00][k] = e0_ff[k] * e0_ff[k];
         pr_in[D01][k] = e0_ff[k] * e1_ff[k];
         pr_in[D11][k] = e1_ff[k] * e1_ff[k];
         pr_in[D20][k] = e2_ff[k] * e0_ff[k];
         pr_in[D21][k] = e2_ff[k] * e1_ff[k];
      end
   end

   // Dot products as three-term sums.
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         dot_in[i] = DW'(pr_ff[i][0]) + DW'(pr_ff[i][1]) + DW'(pr_ff[i][2]);
      end
   end

   // Partial products of the wide products, split into signed high and
   // unsigned low halves.
   always_comb begin
      logic signed [DW-HW-1:0] xh, yh;
      logic signed [HW:0]      xl, yl;
      xh = '0;
      yh = '0;
      xl = '0;
      yl = '0;
      for (int j = 0; j < 6; j++) begin
         xh = $signed(dot_ff[PX[j]][DW-1:HW]);
         yh = $signed(dot_ff[PY[j]][DW-1:HW]);
         xl = $signed({1'b0, dot_ff[PX[j]][HW-1:0]});
         yl = $signed({1'b0, dot_ff[PY[j]][HW-1:0]});
         hh_in[j] = xh * yh;
         hl_in[j] = xh * yl;
         lh_in[j] = xl * yh;
         ll_in[j] = xl * yl;
      end
   end

   // Recombine the partial products.
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         prod_in[j] = (PW'(hh_ff[j]) <<< (2*HW))
                    + ((PW'(hl_ff[j]) + PW'(lh_ff[j])) <<< HW)
                    + PW'(ll_ff[j]);
      end
   end

   // Denominator and the numerators of v and w.
   assign den6_in = NW'(prod_ff[0]) - NW'(prod_ff[1]);
   assign nv6_in  = NW'(prod_ff[2]) - NW'(prod_ff[3]);
   assign nw6_in  = NW'(prod_ff[4]) - NW'(prod_ff[5]);

   // Numerator of u and the degenerate flag.
   assign nu_in  = den6_ff - nv6_ff - nw6_ff;
   assign deg_in = (den6_ff == '0);

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
               vld_ff[s] <= vld_prev[s];
            end
         end
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         e0_ff <= e0_in;
         e1_ff <= e1_in;
         e2_ff <= e2_in;
      end
      if (en[1]) begin
         pr_ff <= pr_in;
      end
      if (en[2]) begin
         dot_ff <= dot_in;
      end
      if (en[3]) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
      end
      if (en[4]) begin
         prod_ff <= prod_in;
      end
      if (en[5]) begin
         den6_ff <= den6_in;
         nv6_ff  <= nv6_in;
         nw6_ff  <= nw6_in;
      end
      if (en[6]) begin
         den_ff <= den6_ff;
         nv_ff  <= nv6_ff;
         nw_ff  <= nw6_ff;
         nu_ff  <= nu_in;
         deg_ff <= deg_in;
      end
   end

   assign out_valid      = vld_ff[NS-1];
   assign out_den        = den_ff;
   assign out_nv         = nv_ff;
   assign out_nw         = nw_ff;
   assign out_nu         = nu_ff;
   assign out_degenerate = deg_ff;

endmodule

/* design/bcc_queue.sv */
// Short item queue between the front and back ends of the barycentric unit.
// Generic width; no package dependency.
module bcc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_full,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_stall,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW-1:0]    wr_ptr_in, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             push, pop;

   assign push_full = (count_ff == CNTW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign push      = push_valid && !push_full;
   assign pop       = pop_valid && !pop_stall;
   assign pop_data  = mem[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/bcc_back.sv */
// Back end of the barycentric unit: three pipelined restoring dividers that
// share one divisor, followed by saturation and the output register.
// Depends on bcc_pkg for the result format.
module bcc_back #(
   parameter int NW   = 74,
   parameter int FRAC = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_stall,
   input  logic signed [NW-1:0]                    in_den,
   input  logic signed [NW-1:0]                    in_nu,
   input  logic signed [NW-1:0]                    in_nv,
   input  logic signed [NW-1:0]                    in_nw,
   input  logic                                    in_degenerate,
   output logic                                    out_valid,
   input  logic                                    out_stall,
   output logic signed [bcc_pkg::RESULT_WIDTH-1:0] out_u,
   output logic signed [bcc_pkg::RESULT_WIDTH-1:0] out_v,
   output logic signed [bcc_pkg::RESULT_WIDTH-1:0] out_w,
   output logic                                    out_degenerate
);

   import bcc_pkg::*;

   localparam int QB = QUOT_BITS;
   localparam int RW = NW + QB;
   localparam int NS = QB + 3;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_prev;
   logic [NS:0]   en;

   // Sign handling stage.
   logic signed [NW-1:0] num [3];
   logic [NW-1:0]        magn_ff [3], magn_in [3];
   logic [NW-1:0]        magd_ff, magd_in;
   logic                 neg0_ff [3], neg0_in [3];
   logic                 deg0_ff;

   // Division pipeline, index 0 is the setup stage.
   logic [RW-1:0] rem_ff [QB+1][3];
   logic [RW-1:0] rem_in [QB+1][3];
   logic [QB-1:0] q_ff   [QB+1][3];
   logic [QB-1:0] q_in   [QB+1][3];
   logic          sat_ff [QB+1][3];
   logic          sat_in [3];
   logic          neg_ff [QB+1][3];
   logic          deg_ff [QB+1];
   logic [NW-1:0] div_ff [QB];

   logic [RESULT_WIDTH-1:0] res_ff [3], res_in [3];
   logic                    resdeg_ff;

   // Stall chain.
   always_comb begin
      en[NS] = !out_stall;
      for (int s = NS-1; s >= 0; s--) begin
         en[s] = !vld_ff[s] || en[s+1];
      end
   end

   assign vld_prev = {vld_ff[NS-2:0], in_valid};
   assign in_stall = !en[0];

   // Magnitudes and result signs.
   assign num[0] = in_nu;
   assign num[1] = in_nv;
   assign num[2] = in_nw;
   assign magd_in = in_den[NW-1] ? (~in_den + 1'b1) : in_den;
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         magn_in[l] = num[l][NW-1] ? (~num[l] + 1'b1) : num[l];
         neg0_in[l] = num[l][NW-1] ^ in_den[NW-1];
      end
   end

   // Out-of-range check before the first division step.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         sat_in[l] = (RW'(magn_ff[l]) << FRAC) >= (RW'(magd_ff) << QB);
      end
   end

   // Scaled dividend in the setup stage, then one quotient bit per stage,
   // most significant first.
   always_comb begin
      logic [RW-1:0] trial;
      logic          ge;
      trial = '0;
      ge    = 1'b0;
      for (int l = 0; l < 3; l++) begin
         rem_in[0][l] = RW'(magn_ff[l]) << FRAC;
         q_in[0][l]   = '0;
      end
      for (int t = 0; t < QB; t++) begin
         for (int l = 0; l < 3; l++) begin
            trial = RW'(div_ff[t]) << (QB - 1 - t);
            ge    = rem_ff[t][l] >= trial;
            rem_in[t+1][l] = ge ? rem_ff[t][l] - trial : rem_ff[t][l];
            q_in[t+1][l]   = {q_ff[t][l][QB-2:0], ge};
         end
      end
   end

   // Sign, clamp and degenerate override.
   always_comb begin
      logic [QB-1:0] q;
      q = '0;
      for (int l = 0; l < 3; l++) begin
         q = q_ff[QB][l];
         if (deg_ff[QB]) begin
            res_in[l] = '0;
         end else if (neg_ff[QB][l]) begin
            if (sat_ff[QB][l] || q > {1'b0, RES_MIN}) begin
               res_in[l] = RES_MIN;
            end else begin
               res_in[l] = ~q[RESULT_WIDTH-1:0] + 1'b1;
            end
         end else begin
            if (sat_ff[QB][l] || q > {1'b0, RES_MAX}) begin
               res_in[l] = RES_MAX;
            end else begin
               res_in[l] = q[RESULT_WIDTH-1:0];
            end
         end
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
               vld_ff[s] <= vld_prev[s];
            end
         end
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         magn_ff <= magn_in;
         magd_ff <= magd_in;
         neg0_ff <= neg0_in;
         deg0_ff <= in_degenerate;
      end
      if (en[1]) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         sat_ff[0] <= sat_in;
         neg_ff[0] <= neg0_ff;
         deg_ff[0] <= deg0_ff;
         div_ff[0] <= magd_ff;
      end
      for (int t = 0; t < QB; t++) begin
         if (en[t+2]) begin
            rem_ff[t+1] <= rem_in[t+1];
            q_ff[t+1]   <= q_in[t+1];
            sat_ff[t+1] <= sat_ff[t];
            neg_ff[t+1] <= neg_ff[t];
            deg_ff[t+1] <= deg_ff[t];
            if (t + 1 < QB) begin
               div_ff[t+1] <= div_ff[t];
            end
         end
      end
      if (en[NS-1]) begin
         res_ff    <= res_in;
         resdeg_ff <= deg_ff[QB];
      end
   end

   assign out_valid      = vld_ff[NS-1];
   assign out_u          = res_ff[0];
   assign out_v          = res_ff[1];
   assign out_w          = res_ff[2];
   assign out_degenerate = resdeg_ff;

endmodule

/* design/barycentric_coordinates_3d_unit.sv */
// Barycentric coordinate unit for a point against a 3D triangle.
//
// Input channel (req_*): one item holds vertices a, b, c and point p as
// signed fixed-point coordinates; it is accepted at a clock edge where
// req_valid is high and req_stall is low.
// Result channel (rsp_*): one item per input, the weights u, v, w as signed
// values with RESULT_FRAC_BITS fraction bits, clamped to 32 bits, and a
// degenerate flag (weights zero) when the triangle has no area.
// Throughput is one item per cycle while rsp_stall is low. Without stalls,
// an accepted item passes the 6 front-end stages after the one that takes
// it, the queue and 36 back-end stages, of which 33 are the one-bit-per-stage
// dividers.
// When the receiver holds rsp_stall, the result stays on the port, the back
// end fills up, the four-entry queue and then the front-end stages fill,
// and only then does req_stall rise. Synchronous reset empties every stage
// and the queue; no item is in flight afterwards.
// Depends on bcc_pkg, bcc_front, bcc_queue and bcc_back.
module barycentric_coordinates_3d_unit #(
   parameter int COORD_WIDTH      = 16,
   parameter int RESULT_FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [COORD_WIDTH-1:0]           req_ax,
   input  logic signed [COORD_WIDTH-1:0]           req_ay,
   input  logic signed [COORD_WIDTH-1:0]           req_az,
   input  logic signed [COORD_WIDTH-1:0]           req_bx,
   input  logic signed [COORD_WIDTH-1:0]           req_by,
   input  logic signed [COORD_WIDTH-1:0]           req_bz,
   input  logic signed [COORD_WIDTH-1:0]           req_cx,
   input  logic signed [COORD_WIDTH-1:0]           req_cy,
   input  logic signed [COORD_WIDTH-1:0]           req_cz,
   input  logic signed [COORD_WIDTH-1:0]           req_px,
   input  logic signed [COORD_WIDTH-1:0]           req_py,
   input  logic signed [COORD_WIDTH-1:0]           req_pz,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [bcc_pkg::RESULT_WIDTH-1:0] rsp_weight_u,
   output logic signed [bcc_pkg::RESULT_WIDTH-1:0] rsp_weight_v,
   output logic signed [bcc_pkg::RESULT_WIDTH-1:0] rsp_weight_w,
   output logic                                    rsp_degenerate
);

   import bcc_pkg::*;

   localparam int NW     = 4*COORD_WIDTH + 10;
   localparam int QWIDTH = 4*NW + 1;
   localparam int QDEPTH = 4;

   logic signed [COORD_WIDTH-1:0] vert_a [3], vert_b [3], vert_c [3], point_p [3];

   logic                 fr_valid, fr_full;
   logic signed [NW-1:0] fr_den, fr_nv, fr_nw, fr_nu;
   logic                 fr_deg;
   logic [QWIDTH-1:0]    q_push_data, q_pop_data;
   logic                 q_valid, bk_stall;

   assign vert_a[0]  = req_ax;
   assign vert_a[1]  = req_ay;
   assign vert_a[2]  = req_az;
   assign vert_b[0]  = req_bx;
   assign vert_b[1]  = req_by;
   assign vert_b[2]  = req_bz;
   assign vert_c[0]  = req_cx;
   assign vert_c[1]  = req_cy;
   assign vert_c[2]  = req_cz;
   assign point_p[0] = req_px;
   assign point_p[1] = req_py;
   assign point_p[2] = req_pz;

   // Front end: geometry down to numerators and denominator.
   bcc_front #(
      .CW (COORD_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_stall       (req_stall),
      .vert_a         (vert_a),
      .vert_b         (vert_b),
      .vert_c         (vert_c),
      .point_p        (point_p),
      .out_valid      (fr_valid),
      .out_full       (fr_full),
      .out_den        (fr_den),
      .out_nv         (fr_nv),
      .out_nw         (fr_nw),
      .out_nu         (fr_nu),
      .out_degenerate (fr_deg)
   );

   assign q_push_data = {fr_deg, fr_nu, fr_nw, fr_nv, fr_den};

   // Decoupling queue.
   bcc_queue #(
      .WIDTH (QWIDTH),
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_full  (fr_full),
      .push_data  (q_push_data),
      .pop_valid  (q_valid),
      .pop_stall  (bk_stall),
      .pop_data   (q_pop_data)
   );

   // Back end: division and clamping.
   bcc_back #(
      .NW   (NW),
      .FRAC (RESULT_FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (q_valid),
      .in_stall       (bk_stall),
      .in_den         ($signed(q_pop_data[NW-1:0])),
      .in_nv          ($signed(q_pop_data[2*NW-1:NW])),
      .in_nw          ($signed(q_pop_data[3*NW-1:2*NW])),
      .in_nu          ($signed(q_pop_data[4*NW-1:3*NW])),
      .in_degenerate  (q_pop_data[4*NW]),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .out_u          (rsp_weight_u),
      .out_v          (rsp_weight_v),
      .out_w          (rsp_weight_w),
      .out_degenerate (rsp_degenerate)
   );

endmodule

/* design/bcc_checker.sv */
// Port-level checks for the barycentric coordinate unit, bound to its top level.
// Depends on bcc_pkg for the result width.
module bcc_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [bcc_pkg::RESULT_WIDTH-1:0] rsp_weight_u,
   input logic signed [bcc_pkg::RESULT_WIDTH-1:0] rsp_weight_v,
   input logic signed [bcc_pkg::RESULT_WIDTH-1:0] rsp_weight_w,
   input logic                                    rsp_degenerate
);

   // Reset leaves no result on the port.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result item holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight_u)
         && $stable(rsp_weight_v) && $stable(rsp_weight_w) && $stable(rsp_degenerate))
      else $error("stalled result item changed");

   // A degenerate triangle reports zero weights.
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_weight_u == '0 && rsp_weight_v == '0
         && rsp_weight_w == '0)
      else $error("degenerate item with nonzero weights");

   // Weights of a proper triangle sum to one, so they are never all zero.
   a_nonzero_weights: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> !(rsp_weight_u == '0 && rsp_weight_v == '0
         && rsp_weight_w == '0))
      else $error("proper triangle with all weights zero");

endmodule

bind barycentric_coordinates_3d_unit bcc_checker u_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench for barycentric_coordinates_3d_unit.
// Sends directed and random triangle queries and checks every result item
// against an exact integer predictor. Depends on bcc_pkg and the unit itself.
`timescale 1ns / 100ps

module testbench;
   import bcc_pkg::*;

   localparam int CW          = 16;
   localparam int FRAC        = 16;
   localparam int LATENCY     = 43;
   localparam int IDLE_LIMIT  = 5000;
   localparam int UNIT        = 256;   // 1.0 in Q8.8

   typedef logic signed [CW-1:0] coord_type;
   // Coordinates in port order: a x y z, b x y z, c x y z, p x y z.
   typedef struct { coord_type c[12]; } query_type;
   typedef struct {
      logic signed [RESULT_WIDTH-1:0] u;
      logic signed [RESULT_WIDTH-1:0] v;
      logic signed [RESULT_WIDTH-1:0] w;
      logic                           degen;
   } weights_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   coord_type req_ax, req_ay, req_az, req_bx, req_by, req_bz;
   coord_type req_cx, req_cy, req_cz, req_px, req_py, req_pz;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [RESULT_WIDTH-1:0] rsp_weight_u, rsp_weight_v, rsp_weight_w;
   logic rsp_degenerate;

   weights_type pending_weights[$];
   int          error_count;
   int          quiet_cycles;
   int          stall_left;
   bit          calm;

   barycentric_coordinates_3d_unit #(
      .COORD_WIDTH(CW),
      .RESULT_FRAC_BITS(FRAC)
   ) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_ax(req_ax), .req_ay(req_ay), .req_az(req_az),
      .req_bx(req_bx), .req_by(req_by), .req_bz(req_bz),
      .req_cx(req_cx), .req_cy(req_cy), .req_cz(req_cz),
      .req_px(req_px), .req_py(req_py), .req_pz(req_pz),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_weight_u(rsp_weight_u), .rsp_weight_v(rsp_weight_v),
      .rsp_weight_w(rsp_weight_w), .rsp_degenerate(rsp_degenerate)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Scaled quotient num * 2^FRAC / den, truncated toward zero and clamped.
   function automatic logic signed [RESULT_WIDTH-1:0] scaled_ratio(
      input logic signed [127:0] num, input logic signed [127:0] den);
      logic         neg;
      logic [127:0] n_mag, d_mag, q;
      neg   = (num < 0) != (den < 0);
      n_mag = (num < 0) ? -num : num;
      d_mag = (den < 0) ? -den : den;
      q     = (n_mag << FRAC) / d_mag;
      if (neg) begin
         if (q > 128'h8000_0000) return RES_MIN;
         return -q[RESULT_WIDTH-1:0];
      end
      if (q > 128'h7FFF_FFFF) return RES_MAX;
      return q[RESULT_WIDTH-1:0];
   endfunction

   // Exact barycentric weights of point p in triangle a, b, c.
   function automatic weights_type barycentric_weights(input query_type q);
      weights_type         r;
      logic signed [127:0] va, e0, e1, e2;
      logic signed [127:0] d00, d01, d11, d20, d21, den, nv, nw;
      d00 = '0; d01 = '0; d11 = '0; d20 = '0; d21 = '0;
      for (int k = 0; k < 3; k++) begin
         va = 128'(q.c[k]);
         e0 = 128'(q.c[3+k]) - va;
         e1 = 128'(q.c[6+k]) - va;
         e2 = 128'(q.c[9+k]) - va;
         d00 += e0 * e0;
         d01 += e0 * e1;
         d11 += e1 * e1;
         d20 += e2 * e0;
         d21 += e2 * e1;
      end
      den = d00 * d11 - d01 * d01;
      if (den == 0) begin
         r.u = '0; r.v = '0; r.w = '0; r.degen = 1'b1;
         return r;
      end
      nv = d11 * d20 - d01 * d21;
      nw = d00 * d21 - d01 * d20;
      r.u = scaled_ratio(den - nv - nw, den);
      r.v = scaled_ratio(nv, den);
      r.w = scaled_ratio(nw, den);
      r.degen = 1'b0;
      return r;
   endfunction

   // Sends one item and records its expected weights once it is accepted.
   task automatic send_query(input query_type q);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_ax, req_ay, req_az} <= {q.c[0], q.c[1], q.c[2]};
      {req_bx, req_by, req_bz} <= {q.c[3], q.c[4], q.c[5]};
      {req_cx, req_cy, req_cz} <= {q.c[6], q.c[7], q.c[8]};
      {req_px, req_py, req_pz} <= {q.c[9], q.c[10], q.c[11]};
      do @(posedge clock); while (req_stall);
      pending_weights.push_back(barycentric_weights(q));
   endtask

   // Holds the sender until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_weights.size() != 0) @(posedge clock);
   endtask

   function automatic coord_type rand_in(input int span);
      return coord_type'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic query_type make_query(input int a[3], input int b[3],
                                            input int c[3], input int p[3]);
      query_type q;
      for (int k = 0; k < 3; k++) begin
         q.c[k]   = coord_type'(a[k]);
         q.c[3+k] = coord_type'(b[k]);
         q.c[6+k] = coord_type'(c[k]);
         q.c[9+k] = coord_type'(p[k]);
      end
      return q;
   endfunction

   // Random query of one of several shapes.
   function automatic query_type random_query();
      query_type q;
      int        kind, k_mul;
      coord_type base, step;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 12; i++) q.c[i] = coord_type'($urandom);
      case (kind)
         3, 4, 5: begin
            // Moderate triangle with the point nearby.
            for (int k = 0; k < 3; k++) begin
               base = rand_in(20000);
               q.c[k]   = base;
               q.c[3+k] = base + rand_in(2000);
               q.c[6+k] = base + rand_in(2000);
               q.c[9+k] = base + rand_in(3000);
            end
         end
         6: begin
            // Collinear vertices.
            k_mul = int'($urandom_range(0, 6)) - 3;
            for (int k = 0; k < 3; k++) begin
               base = rand_in(20000);
               step = rand_in(100);
               q.c[k]   = base;
               q.c[3+k] = base + step;
               q.c[6+k] = base + coord_type'(k_mul) * step;
            end
         end
         7: begin
            // Two vertices coincide.
            for (int k = 0; k < 3; k++) q.c[3+k] = q.c[k];
         end
         8, 9: begin
            // Tiny triangle and a point anywhere, which drives saturation.
            for (int k = 0; k < 3; k++) begin
               q.c[3+k] = q.c[k] + rand_in(4);
               q.c[6+k] = q.c[k] + rand_in(4);
            end
         end
         default: ;
      endcase
      return q;
   endfunction

   task automatic test_directed();
      int m, n;
      m = -32768; n = 32767;
      // Every coordinate zero: degenerate.
      send_query(make_query('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
      // Unit right triangle with the point at each vertex, then the centroid of a triangle three units wide.
      send_query(make_query('{0, 0, 0}, '{UNIT, 0, 0}, '{0, UNIT, 0}, '{0, 0, 0}));
      send_query(make_query('{0, 0, 0}, '{UNIT, 0, 0}, '{0, UNIT, 0}, '{UNIT, 0, 0}));
      send_query(make_query('{0, 0, 0}, '{UNIT, 0, 0}, '{0, UNIT, 0}, '{0, UNIT, 0}));
      send_query(make_query('{0, 0, 0}, '{768, 0, 0}, '{0, 768, 0}, '{UNIT, UNIT, 0}));
      // Point off the plane and outside the triangle.
      send_query(make_query('{0, 0, 0}, '{UNIT, 0, 0}, '{0, UNIT, 0}, '{-512, 900, 77}));
      // Extreme coordinates.
      send_query(make_query('{m, m, m}, '{n, m, m}, '{m, n, m}, '{n, n, n}));
      send_query(make_query('{n, n, n}, '{m, n, n}, '{n, m, n}, '{m, m, m}));
      send_query(make_query('{m, n, m}, '{n, m, n}, '{m, m, n}, '{n, m, m}));
      send_query(make_query('{n, n, n}, '{n, n, n}, '{n, n, n}, '{m, m, m}));
      // Collinear and coincident vertices.
      send_query(make_query('{0, 0, 0}, '{1, 1, 1}, '{2, 2, 2}, '{5, 7, 9}));
      send_query(make_query('{m, 0, 0}, '{0, 0, 0}, '{n, 0, 0}, '{0, n, 0}));
      send_query(make_query('{100, 200, 300}, '{100, 200, 300}, '{5, 6, 7}, '{1, 2, 3}));
      // Smallest triangle, far point: positive and negative saturation.
      send_query(make_query('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{n, n, 0}));
      send_query(make_query('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{m, n, 0}));
      send_query(make_query('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{m, m, n}));
      send_query(make_query('{n, n, n}, '{n - 1, n, n}, '{n, n - 1, n}, '{m, m, m}));
   endtask

   task automatic test_random(input int count);
      repeat (count) send_query(random_query());
   endtask

   // Receiver stall in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result item with the oldest expectation.
   always @(posedge clock) begin
      weights_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_weights.size() == 0) begin
            error_count++;
            $display("%0t: result item with none expected: u=%h v=%h w=%h degenerate=%b",
                     $time, rsp_weight_u, rsp_weight_v, rsp_weight_w, rsp_degenerate);
         end else begin
            exp_w = pending_weights.pop_front();
            if (rsp_weight_u !== exp_w.u) begin
               error_count++;
               $display("%0t: weight_u expected %h actual %h", $time, exp_w.u, rsp_weight_u);
            end
            if (rsp_weight_v !== exp_w.v) begin
               error_count++;
               $display("%0t: weight_v expected %h actual %h", $time, exp_w.v, rsp_weight_v);
            end
            if (rsp_weight_w !== exp_w.w) begin
               error_count++;
               $display("%0t: weight_w expected %h actual %h", $time, exp_w.w, rsp_weight_w);
            end
            if (rsp_degenerate !== exp_w.degen) begin
               error_count++;
               $display("%0t: degenerate expected %b actual %b", $time, exp_w.degen,
                        rsp_degenerate);
            end
         end
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      error_count = 0;
      calm        = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      {req_ax, req_ay, req_az, req_bx, req_by, req_bz} = '0;
      {req_cx, req_cy, req_cz, req_px, req_py, req_pz} = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(600);
      drain_results();
      test_random(600);
      calm = 1'b1;
      test_random(140);
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);

      if (error_count == 0 && pending_weights.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

/* sim.f */
design/bcc_pkg.sv
design/bcc_front.sv
design/bcc_queue.sv
design/bcc_back.sv
design/barycentric_coordinates_3d_unit.sv
design/bcc_checker.sv
tb/sv/testbench.sv
